@@ sv/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C register access master and its
// channel interfaces.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] MAX_READ_COUNT = 8'd255;
   localparam int unsigned MSB_BIT = 7;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic [7:0] read_count;
      logic       sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       sda_output_enable;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
      logic       ack_valid;
      logic       ack_level;
      logic       done_res;
      logic       busy_res;
   } rsp_type;

endpackage

@@ sv/i2cm_if.sv @@
// ----------------------------------------------------------------------------
// i2cm request and response channels
// Valid/ready channels; a request moves at a clock edge with valid and ready.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
   logic              valid;
   logic              ready;
   i2cm_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface i2cm_rsp_if;
   logic              valid;
   logic              ready;
   i2cm_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/i2c_master_register_access_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit
// Bit-level I2C master for register writes and burst reads, one bus delay
// slot per tick request.
// ----------------------------------------------------------------------------
// A new request is taken in each cycle while the response register is empty or
// being drained. A tick request advances the bus sequencer by one delay slot
// and its response (SCL, SDA drive and enable, received byte, sampled
// acknowledge, done and busy) appears in the response register on the next
// cycle. A write or burst-read command is taken only while idle, produces no
// response, and is dropped otherwise. A read count of zero reads one byte.
// Acknowledges from the target are reported but never abort a transfer.
module i2c_master_register_access_unit (
   input  logic          clock,
   input  logic          reset,
   i2cm_req_if.sink      req_chan,
   i2cm_rsp_if.source    rsp_chan
);

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_START     = 5'd1,
      PH_TX_ADDR   = 5'd2,
      PH_ACK_ADDR  = 5'd3,
      PH_TX_REG    = 5'd4,
      PH_ACK_REG   = 5'd5,
      PH_TX_DATA   = 5'd6,
      PH_ACK_DATA  = 5'd7,
      PH_RESTART   = 5'd8,
      PH_TX_RADDR  = 5'd9,
      PH_ACK_RADDR = 5'd10,
      PH_RX        = 5'd11,
      PH_MACK      = 5'd12,
      PH_STOP      = 5'd13
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [1:0] slot_ff, slot_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] left_ff, left_in;
   logic [6:0] addr_ff, addr_in;
   logic [7:0] reg_ff, reg_in;
   logic [7:0] data_ff, data_in;
   logic       is_read_ff, is_read_in;

   logic                rsp_valid_ff, rsp_valid_in;
   i2cm_pkg::rsp_type   rsp_ff, rsp_in;

   logic       accept;
   logic [7:0] tx_value;
   phase_type  tx_next;
   phase_type  ack_next;
   logic [7:0] count_adj;
   logic [7:0] rx_shift;
   logic       last_byte;

   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign last_byte = (left_ff <= 8'd1);
   assign rx_shift  = {shift_ff[6:0], req_chan.payload.sda_level};

   always_comb begin
      count_adj = req_chan.payload.read_count;
      if (count_adj == 8'd0) begin
         count_adj = 8'd1;
      end
      if (count_adj > i2cm_pkg::MAX_READ_COUNT) begin
         count_adj = i2cm_pkg::MAX_READ_COUNT;
      end
   end

   // byte and follow-on phase for the shared transmit and acknowledge slots
   always_comb begin
      tx_value = {addr_ff, 1'b0};
      tx_next  = PH_ACK_ADDR;
      ack_next = PH_TX_REG;
      unique case (phase_ff)
         PH_TX_REG: begin
            tx_value = reg_ff;
            tx_next  = PH_ACK_REG;
         end
         PH_TX_DATA: begin
            tx_value = data_ff;
            tx_next  = PH_ACK_DATA;
         end
         PH_TX_RADDR: begin
            tx_value = {addr_ff, 1'b1};
            tx_next  = PH_ACK_RADDR;
         end
         PH_ACK_REG: begin
            ack_next = is_read_ff ? PH_RESTART : PH_TX_DATA;
         end
         PH_ACK_DATA: begin
            ack_next = PH_STOP;
         end
         PH_ACK_RADDR: begin
            ack_next = PH_RX;
         end
         default: begin
            tx_value = {addr_ff, 1'b0};
            tx_next  = PH_ACK_ADDR;
            ack_next = PH_TX_REG;
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      slot_in      = slot_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      left_in      = left_ff;
      addr_in      = addr_ff;
      reg_in       = reg_ff;
      data_in      = data_ff;
      is_read_in   = is_read_ff;
      rsp_in       = '0;
      rsp_in.busy_res = 1'b1;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (accept) begin
         if (req_chan.payload.kind != i2cm_pkg::KIND_TICK) begin
            if (phase_ff == PH_IDLE &&
                (req_chan.payload.kind == i2cm_pkg::KIND_WRITE ||
                 req_chan.payload.kind == i2cm_pkg::KIND_READ)) begin
               addr_in    = req_chan.payload.device_address;
               reg_in     = req_chan.payload.register_address;
               data_in    = req_chan.payload.write_data;
               is_read_in = (req_chan.payload.kind == i2cm_pkg::KIND_READ);
               left_in    = count_adj;
               phase_in   = PH_START;
               slot_in    = 2'd0;
               bit_in     = 3'd0;
               shift_in   = 8'd0;
            end
         end else begin
            rsp_valid_in = 1'b1;
            unique case (phase_ff)
               PH_START, PH_RESTART: begin
                  rsp_in.scl_level         = 1'b1;
                  rsp_in.sda_output_enable = 1'b1;
                  if (slot_ff == 2'd0) begin
                     rsp_in.sda_drive = 1'b1;
                     slot_in          = 2'd1;
                  end else begin
                     rsp_in.sda_drive = 1'b0;
                     phase_in = (phase_ff == PH_START) ? PH_TX_ADDR : PH_TX_RADDR;
                     slot_in  = 2'd0;
                  end
               end
               PH_TX_ADDR, PH_TX_REG, PH_TX_DATA, PH_TX_RADDR: begin
                  rsp_in.sda_output_enable = 1'b1;
                  priority if (slot_ff == 2'd0) begin
                     // lead-in slot: load the byte
                     shift_in         = tx_value;
                     bit_in           = 3'd0;
                     rsp_in.scl_level = 1'b0;
                     rsp_in.sda_drive = 1'b1;
                     slot_in          = 2'd1;
                  end else if (slot_ff == 2'd1) begin
                     rsp_in.scl_level = 1'b1;
                     rsp_in.sda_drive = shift_ff[i2cm_pkg::MSB_BIT];
                     slot_in          = 2'd2;
                  end else begin
                     rsp_in.scl_level = 1'b0;
                     rsp_in.sda_drive = shift_ff[i2cm_pkg::MSB_BIT];
                     shift_in         = {shift_ff[6:0], 1'b0};
                     if (bit_ff == 3'd7) begin
                        phase_in = tx_next;
                        slot_in  = 2'd0;
                        bit_in   = 3'd0;
                     end else begin
                        bit_in  = bit_ff + 3'd1;
                        slot_in = 2'd1;
                     end
                  end
               end
               PH_ACK_ADDR, PH_ACK_REG, PH_ACK_DATA, PH_ACK_RADDR: begin
                  rsp_in.sda_drive = 1'b1;
                  if (slot_ff == 2'd0) begin
                     rsp_in.scl_level = 1'b1;
                     rsp_in.ack_valid = 1'b1;
                     rsp_in.ack_level = req_chan.payload.sda_level;
                     slot_in          = 2'd1;
                  end else begin
                     rsp_in.scl_level = 1'b0;
                     phase_in         = ack_next;
                     slot_in          = 2'd0;
                     if (phase_ff == PH_ACK_RADDR) begin
                        shift_in = 8'd0;
                        bit_in   = 3'd0;
                     end
                  end
               end
               PH_RX: begin
                  rsp_in.sda_drive = 1'b1;
                  if (slot_ff == 2'd0) begin
                     rsp_in.scl_level = 1'b0;
                     slot_in          = 2'd1;
                  end else begin
                     // sample on the high clock slot
                     rsp_in.scl_level = 1'b1;
                     shift_in         = rx_shift;
                     if (bit_ff == 3'd7) begin
                        rsp_in.read_valid = 1'b1;
                        rsp_in.read_byte  = rx_shift;
                        rsp_in.read_last  = last_byte;
                        phase_in          = PH_MACK;
                        bit_in            = 3'd0;
                     end else begin
                        bit_in = bit_ff + 3'd1;
                     end
                     slot_in = 2'd0;
                  end
               end
               PH_MACK: begin
                  rsp_in.sda_drive         = last_byte;
                  rsp_in.sda_output_enable = 1'b1;
                  if (slot_ff == 2'd0) begin
                     rsp_in.scl_level = 1'b0;
                     slot_in          = 2'd1;
                  end else begin
                     rsp_in.scl_level = 1'b1;
                     slot_in          = 2'd0;
                     if (last_byte) begin
                        phase_in = PH_STOP;
                     end else begin
                        left_in  = left_ff - 8'd1;
                        shift_in = 8'd0;
                        bit_in   = 3'd0;
                        phase_in = PH_RX;
                     end
                  end
               end
               PH_STOP: begin
                  rsp_in.scl_level         = 1'b1;
                  rsp_in.sda_output_enable = 1'b1;
                  if (slot_ff == 2'd0) begin
                     rsp_in.sda_drive = 1'b0;
                     slot_in          = 2'd1;
                  end else begin
                     rsp_in.sda_drive = 1'b1;
                     rsp_in.done_res  = 1'b1;
                     phase_in         = PH_IDLE;
                     slot_in          = 2'd0;
                     bit_in           = 3'd0;
                  end
               end
               default: begin
                  phase_in                 = PH_IDLE;
                  slot_in                  = 2'd0;
                  bit_in                   = 3'd0;
                  rsp_in.scl_level         = 1'b1;
                  rsp_in.sda_drive         = 1'b1;
                  rsp_in.sda_output_enable = 1'b1;
                  rsp_in.busy_res          = 1'b0;
               end
            endcase
         end
      end else if (rsp_valid_ff && !rsp_chan.ready) begin
         // hold the stalled response
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         slot_ff      <= 2'd0;
         bit_ff       <= 3'd0;
         shift_ff     <= 8'd0;
         left_ff      <= 8'd0;
         addr_ff      <= 7'd0;
         reg_ff       <= 8'd0;
         data_ff      <= 8'd0;
         is_read_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         left_ff      <= left_in;
         addr_ff      <= addr_in;
         reg_ff       <= reg_in;
         data_ff      <= data_in;
         is_read_ff   <= is_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   a_idle_slot_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> slot_ff == 2'd0 && bit_ff == 3'd0)
      else $error("idle phase with slot or bit count left over");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff != 2'd3)
      else $error("slot index out of range");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> rsp_ff.busy_res && phase_ff == PH_IDLE)
      else $error("done reported without finishing the transaction");

   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.busy_res |->
         rsp_ff.scl_level && rsp_ff.sda_drive && rsp_ff.sda_output_enable &&
         !rsp_ff.read_valid && !rsp_ff.ack_valid)
      else $error("idle response does not hold the bus high");

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.read_valid && rsp_ff.ack_valid))
      else $error("read byte and target acknowledge in one slot");

endmodule

@@ tb/i2c_master_register_access_unit_tb.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit_tb
// Drives tick and command requests into the I2C register access master and
// checks every slot response against an in-bench model of the bus sequencer.
// Covers register writes, burst reads of one to twelve bytes and commands that
// must be dropped, with random request gaps and response stalls throughout.
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 1100;
   localparam int         TAIL_CYCLES  = 20;
   localparam int         WRITE_SLOTS  = 61;
   localparam int         READ_SLOTS   = 63;
   localparam int         BYTE_SLOTS   = 18;

   typedef enum logic [4:0] {
      ST_IDLE, ST_START, ST_TX_ADDR, ST_ACK_ADDR, ST_TX_REG, ST_ACK_REG,
      ST_TX_DATA, ST_ACK_DATA, ST_RESTART, ST_TX_RADDR, ST_ACK_RADDR,
      ST_RX, ST_MACK, ST_STOP
   } bus_phase_type;

   typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_type;

   typedef struct {
      i2cm_pkg::req_type req;
      bit                drain_first;
   } queued_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cm_req_if req_if ();
   i2cm_rsp_if rsp_if ();

   i2c_master_register_access_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   queued_req_type    request_queue[$];
   i2cm_pkg::rsp_type slots_due[$];
   int                mismatches   = 0;
   int                items_issued = 0;
   bit                req_moved    = 1'b0;

   // bus sequencer model
   bus_phase_type bus_phase  = ST_IDLE;
   logic [1:0]    bus_slot   = '0;
   logic [2:0]    bit_pos    = '0;
   logic [7:0]    shift_reg  = '0;
   logic [7:0]    bytes_left = '0;
   logic [6:0]    dev_hold   = '0;
   logic [7:0]    reg_hold   = '0;
   logic [7:0]    data_hold  = '0;
   logic          read_cmd   = 1'b0;

   function automatic void send_slot(input logic [7:0] value,
                                     input bus_phase_type nxt,
                                     inout i2cm_pkg::rsp_type e);
      e.sda_output_enable = 1'b1;
      if (bus_slot == 2'd0) begin
         shift_reg   = value;
         bit_pos     = '0;
         e.scl_level = 1'b0;
         e.sda_drive = 1'b1;
         bus_slot    = 2'd1;
      end else if (bus_slot == 2'd1) begin
         e.scl_level = 1'b1;
         e.sda_drive = shift_reg[i2cm_pkg::MSB_BIT];
         bus_slot    = 2'd2;
      end else begin
         e.scl_level = 1'b0;
         e.sda_drive = shift_reg[i2cm_pkg::MSB_BIT];
         shift_reg   = shift_reg << 1;
         if (bit_pos == 3'd7) begin
            bus_phase = nxt;
            bus_slot  = 2'd0;
            bit_pos   = '0;
         end else begin
            bit_pos  = bit_pos + 3'd1;
            bus_slot = 2'd1;
         end
      end
   endfunction

   function automatic void target_ack_slot(input logic sda, input bus_phase_type nxt,
                                           inout i2cm_pkg::rsp_type e);
      e.sda_drive         = 1'b1;
      e.sda_output_enable = 1'b0;
      if (bus_slot == 2'd0) begin
         e.scl_level = 1'b1;
         e.ack_valid = 1'b1;
         e.ack_level = sda;
         bus_slot    = 2'd1;
      end else begin
         e.scl_level = 1'b0;
         bus_phase   = nxt;
         bus_slot    = 2'd0;
      end
   endfunction

   function automatic void start_cond_slot(input bus_phase_type nxt,
                                           inout i2cm_pkg::rsp_type e);
      e.scl_level         = 1'b1;
      e.sda_output_enable = 1'b1;
      if (bus_slot == 2'd0) begin
         e.sda_drive = 1'b1;
         bus_slot    = 2'd1;
      end else begin
         e.sda_drive = 1'b0;
         bus_phase   = nxt;
         bus_slot    = 2'd0;
      end
   endfunction

   // Advance the sequencer model by one accepted request.
   function automatic void step_bus_master(input i2cm_pkg::req_type r);
      i2cm_pkg::rsp_type e;
      e = '0;
      if (r.kind != i2cm_pkg::KIND_TICK) begin
         if (bus_phase == ST_IDLE && (r.kind == i2cm_pkg::KIND_WRITE ||
                                      r.kind == i2cm_pkg::KIND_READ)) begin
            dev_hold   = r.device_address;
            reg_hold   = r.register_address;
            data_hold  = r.write_data;
            read_cmd   = (r.kind == i2cm_pkg::KIND_READ);
            bytes_left = (r.read_count == 8'd0) ? 8'd1 : r.read_count;
            if (bytes_left > i2cm_pkg::MAX_READ_COUNT) bytes_left = i2cm_pkg::MAX_READ_COUNT;
            bus_phase  = ST_START;
            bus_slot   = 2'd0;
            bit_pos    = '0;
            shift_reg  = '0;
         end
         return;
      end
      e.busy_res = 1'b1;
      case (bus_phase)
         ST_START:    start_cond_slot(ST_TX_ADDR, e);
         ST_TX_ADDR:  send_slot({dev_hold, 1'b0}, ST_ACK_ADDR, e);
         ST_ACK_ADDR: target_ack_slot(r.sda_level, ST_TX_REG, e);
         ST_TX_REG:   send_slot(reg_hold, ST_ACK_REG, e);
         ST_ACK_REG:  target_ack_slot(r.sda_level, read_cmd ? ST_RESTART : ST_TX_DATA, e);
         ST_TX_DATA:  send_slot(data_hold, ST_ACK_DATA, e);
         ST_ACK_DATA: target_ack_slot(r.sda_level, ST_STOP, e);
         ST_RESTART:  start_cond_slot(ST_TX_RADDR, e);
         ST_TX_RADDR: send_slot({dev_hold, 1'b1}, ST_ACK_RADDR, e);
         ST_ACK_RADDR: begin
            target_ack_slot(r.sda_level, ST_RX, e);
            if (bus_phase == ST_RX) begin
               shift_reg = '0;
               bit_pos   = '0;
            end
         end
         ST_RX: begin
            e.sda_drive = 1'b1;
            if (bus_slot == 2'd0) begin
               e.scl_level = 1'b0;
               bus_slot    = 2'd1;
            end else begin
               e.scl_level = 1'b1;
               shift_reg   = {shift_reg[6:0], r.sda_level};
               if (bit_pos == 3'd7) begin
                  e.read_valid = 1'b1;
                  e.read_byte  = shift_reg;
                  e.read_last  = (bytes_left <= 8'd1);
                  bus_phase    = ST_MACK;
                  bit_pos      = '0;
               end else begin
                  bit_pos = bit_pos + 3'd1;
               end
               bus_slot = 2'd0;
            end
         end
         ST_MACK: begin
            // NACK the final byte, ACK the rest
            e.sda_drive         = (bytes_left <= 8'd1);
            e.sda_output_enable = 1'b1;
            if (bus_slot == 2'd0) begin
               e.scl_level = 1'b0;
               bus_slot    = 2'd1;
            end else begin
               e.scl_level = 1'b1;
               bus_slot    = 2'd0;
               if (bytes_left <= 8'd1) begin
                  bus_phase = ST_STOP;
               end else begin
                  bytes_left = bytes_left - 8'd1;
                  shift_reg  = '0;
                  bit_pos    = '0;
                  bus_phase  = ST_RX;
               end
            end
         end
         ST_STOP: begin
            e.scl_level         = 1'b1;
            e.sda_output_enable = 1'b1;
            if (bus_slot == 2'd0) begin
               e.sda_drive = 1'b0;
               bus_slot    = 2'd1;
            end else begin
               e.sda_drive = 1'b1;
               e.done_res  = 1'b1;
               bus_phase   = ST_IDLE;
               bus_slot    = 2'd0;
               bit_pos     = '0;
            end
         end
         default: begin
            bus_phase           = ST_IDLE;
            bus_slot            = 2'd0;
            bit_pos             = '0;
            e.scl_level         = 1'b1;
            e.sda_drive         = 1'b1;
            e.sda_output_enable = 1'b1;
            e.busy_res          = 1'b0;
         end
      endcase
      slots_due.push_back(e);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_bit(input string name, input logic want,
                                     input logic got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Sample both channels at the rising edge.
   always @(posedge clock) begin : sample_channels
      i2cm_pkg::rsp_type want;
      i2cm_pkg::rsp_type got;
      req_moved = req_if.valid && req_if.ready;
      if (!reset) begin
         if (req_moved) step_bus_master(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (slots_due.size() == 0) begin
               $error("response with no slot outstanding");
               mismatches++;
            end else begin
               want = slots_due.pop_front();
               check_bit("scl_level", want.scl_level, got.scl_level);
               check_bit("sda_drive", want.sda_drive, got.sda_drive);
               check_bit("sda_output_enable", want.sda_output_enable,
                         got.sda_output_enable);
               check_bit("read_valid", want.read_valid, got.read_valid);
               check_field("read_byte", want.read_byte, got.read_byte);
               check_bit("read_last", want.read_last, got.read_last);
               check_bit("ack_valid", want.ack_valid, got.ack_valid);
               check_bit("ack_level", want.ack_level, got.ack_level);
               check_bit("done_res", want.done_res, got.done_res);
               check_bit("busy_res", want.busy_res, got.busy_res);
            end
         end
      end
   end

   int          burst_left = 1;
   int          gap_left   = 0;
   int unsigned stall_tick = 0;

   // Present requests in bursts and stall the response side on its own pattern.
   always @(negedge clock) begin : drive_channels
      logic              nxt_valid;
      i2cm_pkg::req_type nxt_payload;
      logic              nxt_ready;
      nxt_valid   = req_if.valid;
      nxt_payload = req_if.payload;
      if (!reset && (!req_if.valid || req_moved)) begin
         nxt_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (request_queue.size() != 0 &&
                      !(request_queue[0].drain_first && slots_due.size() != 0)) begin
            nxt_payload = request_queue[0].req;
            nxt_valid   = 1'b1;
            request_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
      stall_tick++;
      case (stall_tick[8:7])
         2'd0:    nxt_ready = 1'b1;
         2'd1:    nxt_ready = ($urandom_range(0, 3) != 0);
         2'd2:    nxt_ready = (stall_tick[2:0] != 3'd5);
         default: nxt_ready = 1'($urandom_range(0, 1));
      endcase
      req_if.valid   <= nxt_valid;
      req_if.payload <= nxt_payload;
      rsp_if.ready   <= nxt_ready;
   end

   task automatic add_request(input logic [1:0] kind, input logic [6:0] dev,
                              input logic [7:0] reg_index, input logic [7:0] wdata,
                              input logic [7:0] count, input logic sda,
                              input bit drain);
      queued_req_type q;
      q.req.kind             = kind;
      q.req.device_address   = dev;
      q.req.register_address = reg_index;
      q.req.write_data       = wdata;
      q.req.read_count       = count;
      q.req.sda_level        = sda;
      q.drain_first          = drain;
      request_queue.push_back(q);
   endtask

   task automatic add_tick(input logic sda);
      add_request(i2cm_pkg::KIND_TICK, 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), sda, 1'b0);
      items_issued++;
   endtask

   // A command with random fields, dropped by the block when busy.
   task automatic add_stray_command();
      add_request(2'($urandom_range(1, 3)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
   endtask

   // Queue a command and enough ticks to carry it through the stop condition.
   task automatic add_transaction(input logic [1:0] kind, input logic [6:0] dev,
                                  input logic [7:0] reg_index, input logic [7:0] wdata,
                                  input logic [7:0] count, input sda_mode_type sda_mode,
                                  input bit stray, input bit drain);
      int   slots;
      int   stray_at;
      logic sda;
      slots = (kind == i2cm_pkg::KIND_WRITE) ? WRITE_SLOTS
            : READ_SLOTS + BYTE_SLOTS * ((count == 8'd0) ? 1 : int'(count));
      stray_at = stray ? $urandom_range(0, slots - 1) : -1;
      add_request(kind, dev, reg_index, wdata, count, 1'($urandom_range(0, 1)), drain);
      items_issued++;
      for (int i = 0; i < slots; i++) begin
         if (i == stray_at) add_stray_command();
         case (sda_mode)
            SDA_LOW:  sda = 1'b0;
            SDA_HIGH: sda = 1'b1;
            default:  sda = 1'($urandom_range(0, 1));
         endcase
         add_tick(sda);
      end
      repeat ($urandom_range(0, 3)) add_tick(1'($urandom_range(0, 1)));
   endtask

   initial begin : stimulus
      logic [7:0] count;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;

      // directed: idle slots, dropped kind, field extremes, read counts
      add_tick(1'b0);
      add_tick(1'b1);
      add_request(KIND_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
      add_tick(1'b0);
      add_transaction(i2cm_pkg::KIND_WRITE, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW,
                      1'b0, 1'b0);
      add_transaction(i2cm_pkg::KIND_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, SDA_HIGH,
                      1'b0, 1'b0);
      add_transaction(i2cm_pkg::KIND_WRITE, 7'h2A, 8'h80, 8'h01, 8'h00, SDA_RANDOM,
                      1'b1, 1'b0);
      add_transaction(i2cm_pkg::KIND_READ, 7'h55, 8'hAA, 8'h5A, 8'h00, SDA_LOW,
                      1'b0, 1'b0);
      add_transaction(i2cm_pkg::KIND_READ, 7'h00, 8'h00, 8'h00, 8'h01, SDA_HIGH,
                      1'b0, 1'b0);
      add_transaction(i2cm_pkg::KIND_READ, 7'h3C, 8'h7F, 8'hC3, 8'h02, SDA_RANDOM,
                      1'b1, 1'b0);
      // wait for every outstanding slot before this one
      add_transaction(i2cm_pkg::KIND_READ, 7'h7F, 8'hFF, 8'hFF, 8'h04, SDA_RANDOM,
                      1'b0, 1'b1);

      while (items_issued < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            add_request(KIND_UNUSED, 7'($urandom_range(0, 127)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            add_tick(1'($urandom_range(0, 1)));
         end else begin
            count = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(4, 12));
            add_transaction($urandom_range(0, 1) ? i2cm_pkg::KIND_READ
                                                 : i2cm_pkg::KIND_WRITE,
                            7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), count,
                            ($urandom_range(0, 3) == 0) ? SDA_LOW : SDA_RANDOM,
                            ($urandom_range(0, 6) == 0), ($urandom_range(0, 29) == 0));
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_if.valid) @(posedge clock);
      while (slots_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ i2c_master_register_access_unit.f @@
sv/i2cm_pkg.sv
sv/i2cm_if.sv
sv/i2c_master_register_access_unit.sv
tb/i2c_master_register_access_unit_tb.sv
